// ----- design/swm_pkg.sv -----
`timescale 1ns / 1ps
// shared constants, types and microcode rom of the sliding window median filter
package swm_pkg;

  localparam int VALUE_BITS   = 16;
  localparam int NODE_BITS    = VALUE_BITS + 1;
  localparam int TREE_DEPTH   = 1 << NODE_BITS;
  localparam int WINDOW_DEPTH = 4096;
  localparam int PTR_BITS     = $clog2(WINDOW_DEPTH);
  localparam int WIN_BITS     = 13;
  localparam int COUNT_BITS   = 13;
  localparam int SUM_BITS     = 48;
  localparam int PC_BITS      = 3;

  typedef logic [NODE_BITS-1:0]  node_t;
  typedef logic [VALUE_BITS-1:0] value_t;
  typedef logic [COUNT_BITS-1:0] count_t;
  typedef logic [WIN_BITS-1:0]   win_t;
  typedef logic [PC_BITS-1:0]    pc_t;

  localparam pc_t STEP_IDLE     = 3'd0;
  localparam pc_t STEP_LEAF_NEW = 3'd1;
  localparam pc_t STEP_ADD      = 3'd2;
  localparam pc_t STEP_LEAF_OLD = 3'd3;
  localparam pc_t STEP_SUB      = 3'd4;
  localparam pc_t STEP_COMMIT   = 3'd5;
  localparam pc_t STEP_RANK     = 3'd6;
  localparam pc_t STEP_RESULT   = 3'd7;

  typedef enum logic [2:0] {
    OP_IDLE,
    OP_LEAF_NEW,
    OP_ADD,
    OP_LEAF_OLD,
    OP_SUB,
    OP_COMMIT,
    OP_RANK,
    OP_RESULT
  } op_e;

  typedef enum logic [2:0] {
    COND_NEVER,
    COND_NO_REQ,
    COND_NOT_ROOT,
    COND_NOT_FULL_BEFORE,
    COND_NOT_FULL_NOW,
    COND_NOT_LEAF,
    COND_OUT_BUSY
  } cond_e;

  typedef struct packed {
    op_e   op;
    cond_e cond;
    pc_t   target;
  } ctrl_t;

  typedef struct packed {
    logic no_req;
    logic root;
    logic leaf;
    logic full_before;
    logic full_now;
    logic out_busy;
  } status_t;

  typedef struct packed {
    logic  active;
    node_t addr;
  } clr_t;

  function automatic ctrl_t ucode_rom(pc_t pc);
    ctrl_t w;
    unique case (pc)
      STEP_IDLE:     w = '{op: OP_IDLE,     cond: COND_NO_REQ,          target: STEP_IDLE};
      STEP_LEAF_NEW: w = '{op: OP_LEAF_NEW, cond: COND_NEVER,           target: STEP_IDLE};
      STEP_ADD:      w = '{op: OP_ADD,      cond: COND_NOT_ROOT,        target: STEP_ADD};
      STEP_LEAF_OLD: w = '{op: OP_LEAF_OLD, cond: COND_NOT_FULL_BEFORE, target: STEP_COMMIT};
      STEP_SUB:      w = '{op: OP_SUB,      cond: COND_NOT_ROOT,        target: STEP_SUB};
      STEP_COMMIT:   w = '{op: OP_COMMIT,   cond: COND_NOT_FULL_NOW,    target: STEP_RESULT};
      STEP_RANK:     w = '{op: OP_RANK,     cond: COND_NOT_LEAF,        target: STEP_RANK};
      STEP_RESULT:   w = '{op: OP_RESULT,   cond: COND_OUT_BUSY,        target: STEP_RESULT};
      default:       w = '{op: OP_IDLE,     cond: COND_NEVER,           target: STEP_IDLE};
    endcase
    return w;
  endfunction

endpackage

// ----- design/swm_ram.sv -----
`timescale 1ns / 1ps
// generic ram with one write port and one registered read port
module swm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    rd_data_q <= mem[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

// ----- design/swm_useq.sv -----
`timescale 1ns / 1ps
// microcode sequencer: step counter, control rom and conditional jumps
module swm_useq (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  swm_pkg::status_t status_i,
  output swm_pkg::ctrl_t   ctrl_o
);

  swm_pkg::pc_t   pc_q, pc_d;
  swm_pkg::ctrl_t ctrl;
  logic           cond_met;

  assign ctrl = swm_pkg::ucode_rom(pc_q);

  always_comb begin
    unique case (ctrl.cond)
      swm_pkg::COND_NEVER:           cond_met = 1'b0;
      swm_pkg::COND_NO_REQ:          cond_met = status_i.no_req;
      swm_pkg::COND_NOT_ROOT:        cond_met = !status_i.root;
      swm_pkg::COND_NOT_FULL_BEFORE: cond_met = !status_i.full_before;
      swm_pkg::COND_NOT_FULL_NOW:    cond_met = !status_i.full_now;
      swm_pkg::COND_NOT_LEAF:        cond_met = !status_i.leaf;
      swm_pkg::COND_OUT_BUSY:        cond_met = status_i.out_busy;
      default:                       cond_met = 1'b0;
    endcase
    pc_d = cond_met ? ctrl.target : pc_q + swm_pkg::PC_BITS'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= swm_pkg::STEP_IDLE;
    end else begin
      pc_q <= pc_d;
    end
  end

  assign ctrl_o = ctrl;

endmodule

// ----- design/swm_dpath.sv -----
`timescale 1ns / 1ps
// datapath: count tree and window ring memories, walk registers, result register
module swm_dpath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  swm_pkg::ctrl_t                      ctrl_i,
  output swm_pkg::status_t                    status_o,
  input  swm_pkg::clr_t                       clr_i,
  input  logic                                restart_i,
  input  swm_pkg::win_t                       k_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [swm_pkg::VALUE_BITS-1:0]      sample_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [swm_pkg::VALUE_BITS-1:0]      median_o,
  output logic                                window_full_o,
  output logic [swm_pkg::SUM_BITS-1:0]        median_sum_o
);

  swm_pkg::value_t                  val_q, val_d;
  swm_pkg::node_t                   node_q, node_d, chosen;
  swm_pkg::count_t                  rank_q, rank_d;
  logic [swm_pkg::PTR_BITS-1:0]     ptr_q, ptr_d;
  swm_pkg::win_t                    seen_q, seen_d;
  logic                             full_q, full_d;
  swm_pkg::value_t                  median_q, median_d;
  logic                             out_valid_q, out_valid_d;
  swm_pkg::value_t                  out_median_q, out_median_d;
  logic                             out_full_q, out_full_d;
  logic [swm_pkg::SUM_BITS-1:0]     sum_q, sum_d;

  logic                             tree_we;
  swm_pkg::node_t                   tree_wa;
  swm_pkg::count_t                  tree_wd, tree_rd;
  logic                             ring_we;
  logic [swm_pkg::PTR_BITS-1:0]     ring_ra;
  swm_pkg::value_t                  ring_rd;

  logic in_acc, out_busy, full_before, full_now, go_left;

  assign in_stall_o  = (ctrl_i.op != swm_pkg::OP_IDLE) || clr_i.active || restart_i;
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_busy    = out_valid_q && out_stall_i;
  assign full_before = seen_q >= k_i;
  assign full_now    = full_before || ((seen_q + swm_pkg::WIN_BITS'(1)) == k_i);
  assign go_left     = tree_rd >= rank_q;
  assign chosen      = go_left ? node_q : (node_q | swm_pkg::NODE_BITS'(1));
  assign ring_ra     = ptr_q - k_i[swm_pkg::PTR_BITS-1:0];
  assign ring_we     = ctrl_i.op == swm_pkg::OP_COMMIT;

  assign status_o.no_req      = !(in_valid_i && !clr_i.active && !restart_i);
  assign status_o.root        = node_q == swm_pkg::NODE_BITS'(1);
  assign status_o.leaf        = node_q[swm_pkg::NODE_BITS-1];
  assign status_o.full_before = full_before;
  assign status_o.full_now    = full_now;
  assign status_o.out_busy    = out_busy;

  always_comb begin
    val_d        = in_acc ? sample_i : val_q;
    node_d       = node_q;
    rank_d       = rank_q;
    ptr_d        = ptr_q;
    seen_d       = seen_q;
    full_d       = full_q;
    median_d     = median_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_median_d = out_median_q;
    out_full_d   = out_full_q;
    sum_d        = sum_q;
    tree_we      = 1'b0;
    tree_wa      = node_q;
    tree_wd      = tree_rd;

    unique case (ctrl_i.op)
      swm_pkg::OP_LEAF_NEW: begin
        node_d = {1'b1, val_q};
      end
      swm_pkg::OP_ADD: begin
        tree_we = 1'b1;
        tree_wd = tree_rd + swm_pkg::COUNT_BITS'(1);
        node_d  = node_q >> 1;
      end
      swm_pkg::OP_LEAF_OLD: begin
        node_d = {1'b1, ring_rd};
      end
      swm_pkg::OP_SUB: begin
        tree_we = 1'b1;
        tree_wd = tree_rd - swm_pkg::COUNT_BITS'(1);
        node_d  = node_q >> 1;
      end
      swm_pkg::OP_COMMIT: begin
        ptr_d  = ptr_q + swm_pkg::PTR_BITS'(1);
        seen_d = full_before ? k_i : seen_q + swm_pkg::WIN_BITS'(1);
        full_d = full_now;
        node_d = swm_pkg::NODE_BITS'(2);
        rank_d = swm_pkg::COUNT_BITS'(({1'b0, k_i} + 14'd1) >> 1);
      end
      swm_pkg::OP_RANK: begin
        if (!go_left) begin
          rank_d = rank_q - tree_rd;
        end
        if (node_q[swm_pkg::NODE_BITS-1]) begin
          median_d = chosen[swm_pkg::VALUE_BITS-1:0];
        end else begin
          node_d = {chosen[swm_pkg::VALUE_BITS-1:0], 1'b0};
        end
      end
      swm_pkg::OP_RESULT: begin
        if (!out_busy) begin
          out_valid_d  = 1'b1;
          out_full_d   = full_q;
          out_median_d = full_q ? median_q : '0;
          sum_d        = full_q ? sum_q + swm_pkg::SUM_BITS'(median_q) : sum_q;
        end
      end
      default: begin
      end
    endcase

    if (clr_i.active) begin
      tree_we = 1'b1;
      tree_wa = clr_i.addr;
      tree_wd = '0;
    end
    if (restart_i) begin
      ptr_d  = '0;
      seen_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q       <= '0;
      seen_q      <= '0;
      sum_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      ptr_q       <= ptr_d;
      seen_q      <= seen_d;
      sum_q       <= sum_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q        <= val_d;
    node_q       <= node_d;
    rank_q       <= rank_d;
    full_q       <= full_d;
    median_q     <= median_d;
    out_median_q <= out_median_d;
    out_full_q   <= out_full_d;
  end

  swm_ram #(
    .WIDTH (swm_pkg::COUNT_BITS),
    .DEPTH (swm_pkg::TREE_DEPTH)
  ) u_tree_ram (
    .clk_i     (clk_i),
    .wr_en_i   (tree_we),
    .wr_addr_i (tree_wa),
    .wr_data_i (tree_wd),
    .rd_addr_i (node_d),
    .rd_data_o (tree_rd)
  );

  swm_ram #(
    .WIDTH (swm_pkg::VALUE_BITS),
    .DEPTH (swm_pkg::WINDOW_DEPTH)
  ) u_ring_ram (
    .clk_i     (clk_i),
    .wr_en_i   (ring_we),
    .wr_addr_i (ptr_q),
    .wr_data_i (val_q),
    .rd_addr_i (ring_ra),
    .rd_data_o (ring_rd)
  );

  assign out_valid_o   = out_valid_q;
  assign median_o      = out_median_q;
  assign window_full_o = out_full_q;
  assign median_sum_o  = sum_q;

endmodule

// ----- design/sliding_window_median.sv -----
`timescale 1ns / 1ps
// sliding window median filter top level: config register, tree clear pass, sequencer, datapath
// a request walks the count tree in 17 steps to add its sample and in 17 more to drop the
// oldest once the window was full, then in a 16-step rank walk once it is full, on one tree
// memory; the result step holds while the last result is stalled, and the next request is
// taken after it, while its result waits; after reset and every window size write a pass
// zeroes all 131072 count tree nodes, taking no request; the median sum clears only at reset
module sliding_window_median (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [swm_pkg::WIN_BITS-1:0]        cfg_window_size_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [swm_pkg::VALUE_BITS-1:0]      sample_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [swm_pkg::VALUE_BITS-1:0]      median_o,
  output logic                                window_full_o,
  output logic [swm_pkg::SUM_BITS-1:0]        median_sum_o
);

  swm_pkg::win_t    win_size_q, win_size_d, k;
  swm_pkg::clr_t    clr_q, clr_d;
  swm_pkg::ctrl_t   ctrl;
  swm_pkg::status_t status;
  logic             cfg_wr;

  assign cfg_ready_o = ctrl.op == swm_pkg::OP_IDLE;
  assign cfg_wr      = cfg_valid_i && cfg_ready_o;

  always_comb begin
    if (win_size_q == '0) begin
      k = swm_pkg::WIN_BITS'(1);
    end else if (win_size_q > swm_pkg::WIN_BITS'(swm_pkg::WINDOW_DEPTH)) begin
      k = swm_pkg::WIN_BITS'(swm_pkg::WINDOW_DEPTH);
    end else begin
      k = win_size_q;
    end
  end

  always_comb begin
    win_size_d = cfg_wr ? cfg_window_size_i : win_size_q;
    clr_d      = clr_q;
    if (clr_q.active) begin
      clr_d.addr = clr_q.addr + swm_pkg::NODE_BITS'(1);
      if (clr_q.addr == '1) begin
        clr_d.active = 1'b0;
      end
    end
    if (cfg_wr) begin
      clr_d.active = 1'b1;
      clr_d.addr   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_size_q <= swm_pkg::WIN_BITS'(1);
      clr_q      <= '{active: 1'b1, addr: '0};
    end else begin
      win_size_q <= win_size_d;
      clr_q      <= clr_d;
    end
  end

  swm_useq u_useq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .ctrl_o   (ctrl)
  );

  swm_dpath u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctrl_i        (ctrl),
    .status_o      (status),
    .clr_i         (clr_q),
    .restart_i     (cfg_wr),
    .k_i           (k),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .sample_i      (sample_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .median_o      (median_o),
    .window_full_o (window_full_o),
    .median_sum_o  (median_sum_o)
  );

  a_no_req_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |-> !clr_q.active)
    else $error("request taken during tree clear");

  a_cfg_starts_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_wr |=> (clr_q.active && clr_q.addr == '0))
    else $error("window size write did not restart the tree clear");

  a_not_full_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !window_full_o) |-> (median_o == '0))
    else $error("median not zero while window not full");

  a_sum_on_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!$past(ctrl.op == swm_pkg::OP_RESULT)) |-> $stable(median_sum_o))
    else $error("median sum changed outside result step");

endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 1ps
// self-checking testbench of the sliding window median filter with its own count tree model
module testbench;

  import swm_pkg::*;

  localparam int LEAF_BASE   = 1 << VALUE_BITS;
  localparam int IDLE_LIMIT  = 400000;
  localparam int DRAIN_WAIT  = 80;
  localparam int HOLD_OFF    = 400;

  typedef struct packed {
    value_t              median;
    logic                full;
    logic [SUM_BITS-1:0] sum;
  } median_result_t;

  logic clk_i;
  logic rst_ni = 1'b0;

  logic   cfg_valid = 1'b0;
  win_t   cfg_window_size = '0;
  logic   sample_valid = 1'b0;
  value_t sample_value = '0;
  logic   result_stall = 1'b0;

  logic                cfg_ready_o;
  logic                in_stall_o;
  logic                out_valid_o;
  value_t              median_o;
  logic                window_full_o;
  logic [SUM_BITS-1:0] median_sum_o;

  value_t         pending_samples[$];
  median_result_t expected_medians[$];

  int unsigned         hist_tree [2*LEAF_BASE];
  value_t              recent_samples [WINDOW_DEPTH];
  int unsigned         ring_wr = 0;
  int unsigned         fill_count = 0;
  logic [SUM_BITS-1:0] median_total = '0;
  win_t                window_reg = 13'd1;
  value_t              last_drawn = '0;

  int unsigned send_wait = 0;
  int unsigned send_burst = 0;
  int unsigned recv_wait = 0;
  int unsigned recv_burst = 0;
  int unsigned hold_off_left = 0;
  int unsigned hold_off_mark = 0;
  int unsigned hold_offs = 0;
  int unsigned samples_sent = 0;
  int unsigned results_checked = 0;
  int unsigned errors = 0;
  int unsigned idle_cycles = 0;

  sliding_window_median i_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_valid_i       (cfg_valid),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_window_size_i (cfg_window_size),
    .in_valid_i        (sample_valid),
    .in_stall_o        (in_stall_o),
    .sample_i          (sample_value),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (result_stall),
    .median_o          (median_o),
    .window_full_o     (window_full_o),
    .median_sum_o      (median_sum_o)
  );

  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  function automatic int unsigned active_window();
    if (window_reg == 0) return 1;
    if (window_reg > WINDOW_DEPTH) return WINDOW_DEPTH;
    return window_reg;
  endfunction

  function automatic void clear_window();
    foreach (hist_tree[i]) hist_tree[i] = 0;
    ring_wr = 0;
    fill_count = 0;
  endfunction

  function automatic void count_value(value_t v, bit add);
    int unsigned node;
    node = LEAF_BASE + v;
    while (node >= 1) begin
      if (add) hist_tree[node] = hist_tree[node] + 1;
      else hist_tree[node] = hist_tree[node] - 1;
      node = node >> 1;
    end
  endfunction

  function automatic value_t select_rank(int unsigned rank);
    int unsigned node;
    int unsigned left;
    node = 1;
    while (node < LEAF_BASE) begin
      left = hist_tree[2*node];
      if (left >= rank) begin
        node = 2 * node;
      end else begin
        rank = rank - left;
        node = 2 * node + 1;
      end
    end
    return value_t'(node - LEAF_BASE);
  endfunction

  function automatic median_result_t predict_median(value_t v);
    median_result_t r;
    int unsigned k;
    k = active_window();
    r.median = '0;
    count_value(v, 1'b1);
    if (fill_count >= k) begin
      count_value(recent_samples[(ring_wr + WINDOW_DEPTH - k) % WINDOW_DEPTH], 1'b0);
      fill_count = k;
    end else begin
      fill_count = fill_count + 1;
    end
    recent_samples[ring_wr] = v;
    ring_wr = (ring_wr + 1) % WINDOW_DEPTH;
    r.full = (fill_count == k);
    if (r.full) begin
      r.median = select_rank((k + 1) / 2);
      median_total = median_total + {{(SUM_BITS-VALUE_BITS){1'b0}}, r.median};
    end
    r.sum = median_total;
    return r;
  endfunction

  // mix of full range, tight clusters, edge values and near neighbors
  function automatic value_t draw_sample();
    value_t v;
    case ($urandom_range(0, 9)) inside
      [0:3]:   v = value_t'($urandom);
      [4:5]:   v = value_t'($urandom_range(0, 15));
      6:       v = value_t'($urandom_range(65520, 65535));
      7:       v = $urandom_range(0, 1) ? '1 : '0;
      default: v = last_drawn + value_t'($urandom_range(0, 6)) - value_t'(3);
    endcase
    last_drawn = v;
    return v;
  endfunction

  task automatic queue_samples(int unsigned n);
    repeat (n) pending_samples.push_back(draw_sample());
  endtask

  task automatic wait_drained();
    while (pending_samples.size() != 0 || sample_valid || expected_medians.size() != 0)
      @(posedge clk_i);
  endtask

  task automatic write_window_size(win_t size);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_window_size <= size;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid <= 1'b0;
    window_reg = size;
    clear_window();
  endtask

  // request driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_valid <= 1'b0;
      send_wait <= 0;
      send_burst <= 0;
    end else begin
      if (sample_valid && !in_stall_o) begin
        expected_medians.push_back(predict_median(sample_value));
        samples_sent++;
      end
      if (!sample_valid || !in_stall_o) begin
        if (send_wait != 0) begin
          sample_valid <= 1'b0;
          send_wait <= send_wait - 1;
        end else if (pending_samples.size() != 0) begin
          sample_valid <= 1'b1;
          sample_value <= pending_samples.pop_front();
          if (send_burst != 0) begin
            send_wait <= 0;
            send_burst <= send_burst - 1;
          end else if ($urandom_range(0, 24) == 0) begin
            send_wait <= 0;
            send_burst <= $urandom_range(10, 50);
          end else begin
            send_wait <= $urandom_range(0, 13);
          end
        end else begin
          sample_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk_i or negedge rst_ni) begin : result_check
    median_result_t want;
    int unsigned hold;
    if (!rst_ni) begin
      result_stall <= 1'b0;
    end else begin
      hold = recv_wait;
      if (out_valid_o && !result_stall) begin
        results_checked++;
        if (expected_medians.size() == 0) begin
          $error("result with nothing expected: median %0d", median_o);
          errors++;
        end else begin
          want = expected_medians.pop_front();
          if (median_o !== want.median) begin
            $error("median: expected %0d, got %0d", want.median, median_o);
            errors++;
          end
          if (window_full_o !== want.full) begin
            $error("window_full: expected %0d, got %0d", want.full, window_full_o);
            errors++;
          end
          if (median_sum_o !== want.sum) begin
            $error("median_sum: expected %0d, got %0d", want.sum, median_sum_o);
            errors++;
          end
        end
        if (recv_burst != 0) begin
          hold = 0;
          recv_burst--;
        end else if ($urandom_range(0, 24) == 0) begin
          hold = 0;
          recv_burst = $urandom_range(10, 50);
        end else begin
          hold = $urandom_range(0, 13);
        end
      end else if (out_valid_o && hold != 0) begin
        hold--;
      end
      recv_wait = hold;
      result_stall <= (hold != 0) || (hold_off_left != 0);
    end
  end

  // long output hold-off so the block backs up into its input
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_off_left <= 0;
    end else if (hold_off_left != 0) begin
      hold_off_left <= hold_off_left - 1;
    end else if (results_checked % 1500 == 200 && results_checked != hold_off_mark) begin
      hold_off_left <= HOLD_OFF;
      hold_off_mark <= results_checked;
      hold_offs++;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((sample_valid && !in_stall_o) || (out_valid_o && !result_stall) ||
          (cfg_valid && cfg_ready_o)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout after %0d cycles without a request", idle_cycles);
        $display("sliding_window_median: mismatch");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    clear_window();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // window of one after reset: median follows the sample
    pending_samples = '{16'h0000, 16'hFFFF, 16'h5555, 16'hAAAA, 16'h8000,
                        16'h7FFF, 16'h0001, 16'hFFFE, 16'h0000, 16'h0000};
    queue_samples(150);

    // odd window: fill-up results, ties and extremes
    write_window_size(13'd5);
    pending_samples = '{16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000,
                        16'h0000, 16'h0007, 16'h0007, 16'h0007, 16'h0003, 16'hFFFF};
    queue_samples(400);

    // above the depth: fill-up results only
    write_window_size(13'h1FFF);
    queue_samples(200);

    // zero acts as one
    write_window_size(13'd0);
    queue_samples(150);

    // even window: lower median
    write_window_size(13'd2);
    queue_samples(300);

    // wide window: deep rank walks once full
    write_window_size(13'd300);
    queue_samples(430);

    wait_drained();
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (expected_medians.size() != 0) begin
      $error("%0d results never arrived", expected_medians.size());
      errors++;
    end
    $display("%0d samples sent over window sizes 1, 5, 8191, 0, 2 and 300", samples_sent);
    $display("%0d results checked, %0d long output hold-offs", results_checked, hold_offs);
    if (errors == 0) begin
      $display("sliding_window_median: match");
    end else begin
      $display("sliding_window_median: mismatch");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
design/swm_pkg.sv
design/swm_ram.sv
design/swm_useq.sv
design/swm_dpath.sv
design/sliding_window_median.sv
dv/testbench.sv
